[rtl/core/lgs_pkg.sv]
// ----------------------------------------------------------------------------
// Life generation step: shared package
// Field widths, opcode and register index codes, and the command and status
// groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

    localparam int OPCODE_W = 2;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 5;
    localparam int CFG_W    = 6;
    localparam int CFG_IDX_W = 1;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    // Bit positions of the fields in the slave tdata
    localparam int OPCODE_LSB  = 0;
    localparam int ROW_LSB     = OPCODE_LSB + OPCODE_W;
    localparam int COL_LSB     = ROW_LSB + ROW_W;
    localparam int CELL_IN_LSB = COL_LSB + COL_W;

    localparam logic [OPCODE_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_ADVANCE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLS = 1'b1;

    localparam logic [CFG_W-1:0] ACTIVE_ROWS_RESET = 6'd20;
    localparam logic [CFG_W-1:0] ACTIVE_COLS_RESET = 6'd20;

    // Life rule: birth on three, survival on two or three
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic latch_in;   // capture the incoming transaction
        logic single_rd;  // read the addressed row
        logic single_wb;  // modify or sample the addressed row
        logic adv_step;   // one step of the generation sweep
        logic load_out;   // load the result into the output register
    } lgs_cmd_t;

    typedef struct packed {
        logic adv_last;   // sweep is on its final step
        logic out_free;   // output register can take a result
    } lgs_status_t;

endpackage

`default_nettype wire

[rtl/core/lgs_ram.sv]
// ----------------------------------------------------------------------------
// Life generation step: generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/lgs_ctrl.sv]
// ----------------------------------------------------------------------------
// Life generation step: controller
// Sequences single-cell reads and writes, the generation sweep and the
// hand-off of each result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    input  wire logic [lgs_pkg::OPCODE_W-1:0] in_opcode,
    output logic                             s_tready,
    input  wire lgs_pkg::lgs_status_t        status,
    output lgs_pkg::lgs_cmd_t                cmd
);

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_SINGLE_RD = 5'b00010,
        ST_SINGLE_WB = 5'b00100,
        ST_ADVANCE   = 5'b01000,
        ST_RESPOND   = 5'b10000
    } lgs_state_t;

    lgs_state_t state_reg;
    lgs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
                if (s_tvalid)
                begin
                    unique case (in_opcode) inside
                        lgs_pkg::OP_WRITE,
                        lgs_pkg::OP_READ:   state_next = ST_SINGLE_RD;
                        lgs_pkg::OP_ADVANCE: state_next = ST_ADVANCE;
                        default:             state_next = ST_RESPOND;
                    endcase
                end
            end
            ST_SINGLE_RD:
            begin
                cmd.single_rd = 1'b1;
                state_next    = ST_SINGLE_WB;
            end
            ST_SINGLE_WB:
            begin
                cmd.single_wb = 1'b1;
                state_next    = ST_RESPOND;
            end
            ST_ADVANCE:
            begin
                cmd.adv_step = 1'b1;
                if (status.adv_last)
                begin
                    state_next = ST_RESPOND;
                end
            end
            ST_RESPOND:
            begin
                // hold until the output register has room
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/lgs_dpath.sv]
// ----------------------------------------------------------------------------
// Life generation step: datapath
// Grid memory with per-row valid bits, rolling three-row window for the
// generation sweep, configuration registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_dpath #(
    parameter int GRID_ROWS = 32,
    parameter int GRID_COLS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [lgs_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic      [lgs_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lgs_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire lgs_pkg::lgs_cmd_t             cmd,
    output lgs_pkg::lgs_status_t               status
);

    localparam int AW   = $clog2(GRID_ROWS);
    localparam int CNTW = $clog2(GRID_ROWS + 2);

    // configuration
    logic [lgs_pkg::CFG_W-1:0] active_rows_reg;
    logic [lgs_pkg::CFG_W-1:0] active_cols_reg;

    // captured transaction
    logic [lgs_pkg::OPCODE_W-1:0] op_reg;
    logic [lgs_pkg::ROW_W-1:0]    row_reg;
    logic [lgs_pkg::COL_W-1:0]    col_reg;
    logic                         val_reg;

    logic [CNTW-1:0]      cnt_reg;
    logic [GRID_ROWS-1:0] valid_reg;
    logic                 rd_ok_reg;
    logic                 rd_ok_next;
    logic [GRID_COLS-1:0] prior_reg;
    logic [GRID_COLS-1:0] cur_reg;
    logic                 res_reg;
    logic                 out_valid_reg;
    logic                 out_data_reg;

    // memory ports
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [GRID_COLS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [GRID_COLS-1:0] ram_rdata;

    logic [GRID_COLS-1:0] col_mask;
    logic [GRID_COLS-1:0] col_hit;
    logic [GRID_COLS-1:0] rd_raw;
    logic [GRID_COLS-1:0] rd_row;
    logic [GRID_COLS-1:0] below_row;
    logic [GRID_COLS-1:0] next_row;
    logic [CNTW-1:0]      adv_row;
    logic                 in_window;
    logic                 rd_bit;

    lgs_ram #(
        .WIDTH (GRID_COLS),
        .DEPTH (GRID_ROWS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // column mask and one-hot column select
    always_comb
    begin
        for (int c = 0; c < GRID_COLS; c++)
        begin
            col_mask[c] = (32'(c) < 32'(active_cols_reg));
            col_hit[c]  = (32'(c) == 32'(col_reg));
        end
    end

    assign in_window = (32'(row_reg) < 32'(active_rows_reg)) && (32'(row_reg) < GRID_ROWS)
                    && (32'(col_reg) < 32'(active_cols_reg)) && (32'(col_reg) < GRID_COLS);

    // rows never written and rows outside the window read as dead
    assign rd_raw = rd_ok_reg ? ram_rdata : '0;
    assign rd_row = rd_raw & col_mask;
    assign rd_bit = |(rd_raw & col_hit);

    assign adv_row   = cnt_reg - CNTW'(2);
    assign below_row = (32'(cnt_reg) <= GRID_ROWS) ? rd_row : '0;

    // next generation of the current row from the old window only
    always_comb
    begin
        logic [GRID_COLS+1:0] up_pad;
        logic [GRID_COLS+1:0] mid_pad;
        logic [GRID_COLS+1:0] dn_pad;
        logic [3:0]           nbr;
        up_pad  = {1'b0, prior_reg, 1'b0};
        mid_pad = {1'b0, cur_reg, 1'b0};
        dn_pad  = {1'b0, below_row, 1'b0};
        for (int c = 0; c < GRID_COLS; c++)
        begin
            nbr = 4'(up_pad[c]) + 4'(up_pad[c+1]) + 4'(up_pad[c+2])
                + 4'(mid_pad[c]) + 4'(mid_pad[c+2])
                + 4'(dn_pad[c]) + 4'(dn_pad[c+1]) + 4'(dn_pad[c+2]);
            next_row[c] = (nbr == lgs_pkg::BIRTH_COUNT)
                       || (cur_reg[c] && (nbr == lgs_pkg::SURVIVE_COUNT));
        end
    end

    // memory access
    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = AW'(row_reg);
        ram_wdata  = val_reg ? (rd_raw | col_hit) : (rd_raw & ~col_hit);
        ram_re     = 1'b0;
        ram_raddr  = AW'(row_reg);
        rd_ok_next = (32'(row_reg) < 32'(active_rows_reg)) && (32'(row_reg) < GRID_ROWS)
                  && valid_reg[AW'(row_reg)];
        if (cmd.single_rd)
        begin
            ram_re = 1'b1;
        end
        if (cmd.single_wb && (op_reg == lgs_pkg::OP_WRITE) && in_window)
        begin
            ram_we = 1'b1;
        end
        if (cmd.adv_step)
        begin
            ram_raddr  = cnt_reg[AW-1:0];
            rd_ok_next = (32'(cnt_reg) < 32'(active_rows_reg))
                      && valid_reg[cnt_reg[AW-1:0]];
            ram_re     = (32'(cnt_reg) < GRID_ROWS);
            if (32'(cnt_reg) >= 2)
            begin
                ram_we    = 1'b1;
                ram_waddr = adv_row[AW-1:0];
                ram_wdata = next_row & col_mask;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_rows_reg <= lgs_pkg::ACTIVE_ROWS_RESET;
            active_cols_reg <= lgs_pkg::ACTIVE_COLS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lgs_pkg::REG_ACTIVE_ROWS: active_rows_reg <= cfg_wdata;
                lgs_pkg::REG_ACTIVE_COLS: active_cols_reg <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (cmd.latch_in)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.adv_step)
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg  <= s_tdata[lgs_pkg::OPCODE_LSB +: lgs_pkg::OPCODE_W];
            row_reg <= s_tdata[lgs_pkg::ROW_LSB +: lgs_pkg::ROW_W];
            col_reg <= s_tdata[lgs_pkg::COL_LSB +: lgs_pkg::COL_W];
            val_reg <= s_tdata[lgs_pkg::CELL_IN_LSB];
            res_reg <= 1'b0;
        end
        if (cmd.single_wb)
        begin
            res_reg <= (op_reg == lgs_pkg::OP_READ) && in_window && rd_bit;
        end
        if (ram_re)
        begin
            rd_ok_reg <= rd_ok_next;
        end
        if (cmd.adv_step)
        begin
            // advance the window: above <- current <- below
            if (cnt_reg == CNTW'(1))
            begin
                prior_reg <= '0;
                cur_reg   <= rd_row;
            end
            else if (32'(cnt_reg) >= 2)
            begin
                prior_reg <= cur_reg;
                cur_reg   <= below_row;
            end
        end
        if (cmd.load_out)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign status.adv_last = (32'(cnt_reg) == GRID_ROWS + 1);
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lgs_pkg::M_TDATA_W-1){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

[rtl/core/life_generation_step_core.sv]
// ----------------------------------------------------------------------------
// Life generation step core
// Bit grid of cells with single-cell access and one-generation B3/S23 update.
// ----------------------------------------------------------------------------
// Input stream (s_*): one transaction per command: write a cell, read a cell
// or advance the grid one generation. Every transaction gives exactly one
// result transaction on the output stream (m_*), carrying the cell value for
// a read and zero otherwise.
// A write or read passes through a row read, a write-back and a respond step
// before the next acceptance. An advance sweeps every grid row once through
// the grid memory (one write port, one read port) with a rolling three-row
// window, then loads its result in the respond step.
// The result sits in an output register, so the next command is accepted
// while it waits; if m_tready stays low the core holds in its respond step
// with s_tready low until the register frees.
// Reset clears all cells (per-row valid bits, no clearing pass needed) and
// sets both active-size registers to 20. Configure only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module life_generation_step_core #(
    parameter int GRID_ROWS = 32,
    parameter int GRID_COLS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [1:0] opcode, [6:2] row, [11:7] col, [12] cell_in, [15:13] zero
    input  wire logic [lgs_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [0] cell_out, [7:1] zero
    output logic      [lgs_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lgs_pkg::CFG_W-1:0]     cfg_wdata
);

    lgs_pkg::lgs_cmd_t    cmd;
    lgs_pkg::lgs_status_t status;

    lgs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .in_opcode (s_tdata[lgs_pkg::OPCODE_LSB +: lgs_pkg::OPCODE_W]),
        .s_tready  (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    lgs_dpath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Life generation step core testbench
// Feeds write, read and advance commands to the input stream from a queue,
// predicts every result with a local B3/S23 grid and window-register copy,
// and checks each output transaction in order. Runs a series of active window
// sizes, the extremes among them, with random idling on both streams in most phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int GRID_ROWS       = 32;
    localparam int GRID_COLS       = 32;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTS     = 10;
    localparam int SETTLE_CYCLES   = 40;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 123;

    typedef logic [lgs_pkg::OPCODE_W-1:0] opcode_t;
    typedef logic [lgs_pkg::ROW_W-1:0]    row_t;
    typedef logic [lgs_pkg::COL_W-1:0]    col_t;
    typedef logic [lgs_pkg::CFG_W-1:0]    cfg_t;

    localparam opcode_t OP_UNUSED = 2'd3;

    // window sizes per phase; phase 0 runs on the reset values
    localparam int PHASE_ROWS [NUM_PHASES] = '{20, 32, 1, 63, 0, 9, 3, 32, 6, 17};
    localparam int PHASE_COLS [NUM_PHASES] = '{20, 32, 1, 40, 12, 0, 3, 5, 32, 33};

    // opcode in the lowest bits, cell_in at the top
    typedef struct packed {
        logic    cell_in;
        col_t    col;
        row_t    row;
        opcode_t opcode;
    } life_cmd_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [lgs_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [lgs_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          cfg_we    = 1'b0;
    logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    cfg_t                          cfg_wdata = '0;

    logic [GRID_COLS-1:0] shadow_grid [GRID_ROWS] = '{default: '0};
    cfg_t                 shadow_rows = lgs_pkg::ACTIVE_ROWS_RESET;
    cfg_t                 shadow_cols = lgs_pkg::ACTIVE_COLS_RESET;

    life_cmd_t                     pending_cmds [$];
    logic [lgs_pkg::M_TDATA_W-1:0] expected_cells [$];
    int unsigned          queued_count  = 0;
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_idle_pct = 0;
    bit                   hold_off      = 1'b0;
    int unsigned          fail_count    = 0;
    int unsigned          cycle_count   = 0;

    life_generation_step_core #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Grid predictor
    // ------------------------------------------------------------------------
    function automatic int unsigned rows_in_window();
        return (shadow_rows > GRID_ROWS) ? GRID_ROWS : shadow_rows;
    endfunction

    function automatic int unsigned cols_in_window();
        return (shadow_cols > GRID_COLS) ? GRID_COLS : shadow_cols;
    endfunction

    function automatic int unsigned cell_at(logic [GRID_COLS-1:0] word, int c);
        if (c < 0 || c >= GRID_COLS)
            return 0;
        return 32'(word[c]);
    endfunction

    function automatic void step_generation();
        logic [GRID_COLS-1:0] mask;
        logic [GRID_COLS-1:0] above;
        logic [GRID_COLS-1:0] cur;
        logic [GRID_COLS-1:0] below;
        logic [GRID_COLS-1:0] nxt;
        int unsigned          nr;
        int unsigned          live;
        // a shift of the full width leaves zero, so 32 columns give all ones
        mask  = ~({GRID_COLS{1'b1}} << cols_in_window());
        nr    = rows_in_window();
        above = '0;
        for (int r = 0; r < GRID_ROWS; r++)
        begin
            cur   = (r < nr) ? (shadow_grid[r] & mask) : '0;
            below = (r + 1 < nr) ? (shadow_grid[r + 1] & mask) : '0;
            nxt   = '0;
            for (int c = 0; c < GRID_COLS; c++)
            begin
                live = cell_at(above, c - 1) + cell_at(above, c) + cell_at(above, c + 1)
                     + cell_at(cur, c - 1) + cell_at(cur, c + 1)
                     + cell_at(below, c - 1) + cell_at(below, c) + cell_at(below, c + 1);
                if (cur[c] ? (live == lgs_pkg::SURVIVE_COUNT || live == lgs_pkg::BIRTH_COUNT)
                           : (live == lgs_pkg::BIRTH_COUNT))
                    nxt[c] = 1'b1;
            end
            // the row just above must stay at its old generation
            above          = cur;
            shadow_grid[r] = nxt & mask;
        end
    endfunction

    function automatic logic [lgs_pkg::M_TDATA_W-1:0] predict_result(life_cmd_t cmd);
        logic                          hit;
        logic [lgs_pkg::M_TDATA_W-1:0] res;
        hit = (cmd.row < rows_in_window()) && (cmd.col < cols_in_window());
        res = '0;
        case (cmd.opcode)
            lgs_pkg::OP_WRITE:   if (hit) shadow_grid[cmd.row][cmd.col] = cmd.cell_in;
            lgs_pkg::OP_READ:    if (hit) res[0] = shadow_grid[cmd.row][cmd.col];
            lgs_pkg::OP_ADVANCE: step_generation();
            default:             ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void add_cmd(opcode_t op, row_t r, col_t c, logic v);
        life_cmd_t cmd;
        cmd.opcode  = op;
        cmd.row     = r;
        cmd.col     = c;
        cmd.cell_in = v;
        pending_cmds.push_back(cmd);
        queued_count++;
    endfunction

    // mostly inside the window, now and then anywhere
    function automatic row_t pick_row();
        if (rows_in_window() != 0 && $urandom_range(0, 9) < 8)
            return row_t'($urandom_range(0, rows_in_window() - 1));
        return row_t'($urandom_range(0, GRID_ROWS - 1));
    endfunction

    function automatic col_t pick_col();
        if (cols_in_window() != 0 && $urandom_range(0, 9) < 8)
            return col_t'($urandom_range(0, cols_in_window() - 1));
        return col_t'($urandom_range(0, GRID_COLS - 1));
    endfunction

    task automatic queue_directed();
        // still block in the top-left corner
        add_cmd(lgs_pkg::OP_WRITE, 0, 0, 1'b1);
        add_cmd(lgs_pkg::OP_WRITE, 0, 1, 1'b1);
        add_cmd(lgs_pkg::OP_WRITE, 1, 0, 1'b1);
        add_cmd(lgs_pkg::OP_WRITE, 1, 1, 1'b1);
        // three cells at the far corner of the window: a birth on the edge
        add_cmd(lgs_pkg::OP_WRITE, 19, 19, 1'b1);
        add_cmd(lgs_pkg::OP_WRITE, 19, 18, 1'b1);
        add_cmd(lgs_pkg::OP_WRITE, 18, 19, 1'b1);
        // outside the window, must be dropped
        add_cmd(lgs_pkg::OP_WRITE, 31, 31, 1'b1);
        // blinker
        add_cmd(lgs_pkg::OP_WRITE, 5, 5, 1'b1);
        add_cmd(lgs_pkg::OP_WRITE, 5, 6, 1'b1);
        add_cmd(lgs_pkg::OP_WRITE, 5, 7, 1'b1);
        add_cmd(OP_UNUSED, 31, 31, 1'b1);
        add_cmd(lgs_pkg::OP_READ, 0, 0, 1'b0);
        add_cmd(lgs_pkg::OP_READ, 19, 19, 1'b0);
        add_cmd(lgs_pkg::OP_READ, 31, 31, 1'b0);
        add_cmd(lgs_pkg::OP_READ, 5, 6, 1'b0);
        add_cmd(lgs_pkg::OP_ADVANCE, 0, 0, 1'b0);
        add_cmd(lgs_pkg::OP_READ, 4, 6, 1'b0);
        add_cmd(lgs_pkg::OP_READ, 5, 5, 1'b0);
        add_cmd(lgs_pkg::OP_READ, 18, 18, 1'b0);
        add_cmd(lgs_pkg::OP_READ, 20, 0, 1'b0);
        add_cmd(lgs_pkg::OP_WRITE, 0, 0, 1'b0);
        add_cmd(lgs_pkg::OP_READ, 0, 0, 1'b0);
        add_cmd(lgs_pkg::OP_ADVANCE, 31, 31, 1'b1);
        add_cmd(lgs_pkg::OP_READ, 0, 1, 1'b0);
    endtask

    task automatic queue_random(int unsigned target);
        int unsigned start;
        int unsigned n;
        start = queued_count;
        while (queued_count - start < target)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                // seed a pattern, evolve it, then probe it
                n = $urandom_range(6, 16);
                repeat (n) add_cmd(lgs_pkg::OP_WRITE, pick_row(), pick_col(),
                                   $urandom_range(0, 99) < 70);
                n = $urandom_range(1, 3);
                repeat (n) add_cmd(lgs_pkg::OP_ADVANCE, row_t'($urandom_range(0, 31)),
                                   col_t'($urandom_range(0, 31)), $urandom_range(0, 1) != 0);
                n = $urandom_range(4, 10);
                repeat (n) add_cmd(lgs_pkg::OP_READ, pick_row(), pick_col(),
                                   $urandom_range(0, 1) != 0);
            end
            else
            begin
                add_cmd(opcode_t'($urandom_range(0, 3)), row_t'($urandom_range(0, 31)),
                        col_t'($urandom_range(0, 31)), $urandom_range(0, 1) != 0);
            end
        end
    endtask

    task automatic write_reg(input logic [lgs_pkg::CFG_IDX_W-1:0] idx, input cfg_t val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == lgs_pkg::REG_ACTIVE_ROWS)
            shadow_rows = val;
        else
            shadow_cols = val;
    endtask

    task automatic wait_for_drain();
        while (pending_cmds.size() != 0 || s_tvalid || expected_cells.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // ------------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_cells.push_back(
                    predict_result(life_cmd_t'(s_tdata[$bits(life_cmd_t)-1:0])));
            if (!s_tvalid || s_tready)
            begin
                if (pending_cmds.size() != 0 && !hold_off
                    && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(lgs_pkg::S_TDATA_W - $bits(life_cmd_t)){1'b0}},
                                 pending_cmds.pop_front()};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_cells.size() == 0)
                    note_failure($sformatf("unexpected result transaction: tdata %0h", m_tdata));
                else if (m_tdata !== expected_cells[0])
                    note_failure($sformatf("cell_out mismatch: expected %0h, got %0h",
                                           expected_cells.pop_front(), m_tdata));
                else
                    void'(expected_cells.pop_front());
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_for_drain();
                write_reg(lgs_pkg::REG_ACTIVE_ROWS, cfg_t'(PHASE_ROWS[p]));
                write_reg(lgs_pkg::REG_ACTIVE_COLS, cfg_t'(PHASE_COLS[p]));
            end
            if (p < 4)
            begin
                send_idle_pct = 25;
                recv_idle_pct = 63;
            end
            else if (p < 7)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 25;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 0)
                queue_directed();
            queue_random(ITEMS_PER_PHASE);
            if (p == 1)
            begin
                // hold the sender until every outstanding result is back
                while (pending_cmds.size() > ITEMS_PER_PHASE / 2)
                    @(negedge clk);
                hold_off = 1'b1;
                while (s_tvalid || expected_cells.size() != 0)
                    @(negedge clk);
                hold_off = 1'b0;
            end
        end

        wait_for_drain();
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
